### sv/fad_pkg.sv
`default_nettype none
package fad_pkg;

    localparam int GAIN_FRAC  = 16;
    localparam int GAIN_W     = 17;
    localparam int LEN_W      = 24;
    localparam int START_W    = 32;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SHIFT_W    = 5;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(48000);

    localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXP    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FADE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_CHECK,
        ST_DIV,
        ST_ROM,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               start;
        logic [SHIFT_W-1:0] shift;
    } div_cmd_t;

    // Q4.60 helpers for building the exponential gain ROM at elaboration
    localparam logic [63:0] FX_ONE = 64'h1000_0000_0000_0000;

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    function automatic logic [63:0] atanh_third();
        logic [63:0] sum;
        logic [63:0] p;
        sum = 64'd0;
        p   = FX_ONE / 64'd3;
        for (int N = 1; p != 64'd0; N += 2) begin
            sum = sum + p / 64'(N);
            p   = p / 64'd9;
        end
        return sum;
    endfunction

    function automatic logic [63:0] atanh_ninth();
        logic [63:0] sum;
        logic [63:0] p;
        sum = 64'd0;
        p   = FX_ONE / 64'd9;
        for (int N = 1; p != 64'd0; N += 2) begin
            sum = sum + p / 64'(N);
            p   = p / 64'd81;
        end
        return sum;
    endfunction

    function automatic logic [63:0] ln10_q60();
        logic [63:0] ln2;
        ln2 = 64'd2 * atanh_third();
        return 64'd3 * ln2 + 64'd2 * atanh_ninth();
    endfunction

    localparam logic [63:0] LN10 = ln10_q60();

    // round(65536 * (1 - 0.1^(I / 2^Tbits))), half up
    function automatic logic [GAIN_W-1:0] exp_gain(input int unsigned I,
                                                   input int unsigned Tbits);
        logic [63:0] fmask;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] r;
        fmask = (64'd1 << Tbits) - 64'd1;
        x = (LN10 >> Tbits) * 64'(I) + (((LN10 & fmask) * 64'(I)) >> Tbits);
        y = x >> 3;
        t = FX_ONE;
        e = FX_ONE;
        for (int N = 1; N <= 24; N++) begin
            t = fx_mul(t, y) / 64'(N);
            if ((N & 1) != 0) begin
                e = (e > t) ? e - t : 64'd0;
            end else begin
                e = e + t;
            end
        end
        for (int sq = 0; sq < 3; sq++) begin
            e = fx_mul(e, e);
        end
        if (e > FX_ONE) begin
            e = FX_ONE;
        end
        r = ((FX_ONE - e) + (64'd1 << 43)) >> 44;
        return r[GAIN_W-1:0];
    endfunction

endpackage
`default_nettype wire

### sv/fad_divider.sv
`default_nettype none
// restoring divider: quot = floor((numer << shift) / denom), numer <= denom
module fad_divider
    import fad_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire div_cmd_t          cmd,
    input  wire logic [LEN_W-1:0]  numer,
    input  wire logic [LEN_W-1:0]  denom,
    output logic                   busy,
    output logic                   done,
    output logic [GAIN_W-1:0]      quot
);

    logic               busy_reg;
    logic               done_reg;
    logic [SHIFT_W-1:0] cnt_reg;
    logic [LEN_W-1:0]   rem_reg;
    logic [GAIN_W-1:0]  quot_reg;

    logic [LEN_W:0]     rem_dbl;
    logic               step_bit;
    logic [LEN_W:0]     rem_sub;
    logic               first_bit;

    assign rem_dbl   = {rem_reg, 1'b0};
    assign step_bit  = rem_dbl >= {1'b0, denom};
    assign rem_sub   = rem_dbl - {1'b0, denom};
    assign first_bit = numer >= denom;

    // done is a one-cycle pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.start) begin
            busy_reg <= cmd.shift != '0;
            done_reg <= cmd.shift == '0;
            cnt_reg  <= cmd.shift;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != SHIFT_W'(1);
            done_reg <= cnt_reg == SHIFT_W'(1);
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rem_reg  <= first_bit ? numer - denom : numer;
            quot_reg <= {{(GAIN_W-1){1'b0}}, first_bit};
        end else if (busy_reg) begin
            rem_reg  <= step_bit ? rem_sub[LEN_W-1:0] : rem_dbl[LEN_W-1:0];
            quot_reg <= {quot_reg[GAIN_W-2:0], step_bit};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

### sv/fad_lane.sv
`default_nettype none
// one channel: sample * Q1.16 gain, rounded half up
module fad_lane
    import fad_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic [GAIN_W-1:0]             gain,
    output logic [SAMPLE_BITS-1:0]             result
);

    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
    localparam logic signed [PROD_W-1:0] RND = PROD_W'(1 << (GAIN_FRAC - 1));

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rounded;
    logic [SAMPLE_BITS-1:0]   result_reg;

    assign prod    = PROD_W'(sample) * PROD_W'($signed({1'b0, gain}));
    assign rounded = prod + RND;

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= rounded[SAMPLE_BITS+GAIN_FRAC-1:GAIN_FRAC];
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

### sv/stereo_fadeout_envelope.sv
`default_nettype none
// Channel  Direction  Handshake                  Contents
// s_       in         s_tvalid / s_tready        stereo pair, track_first in s_tuser
// m_       out        m_tvalid / m_tready        faded pair, in_fade, fade_last
// cfg_     in         cfg_valid / cfg_ready      register index and write data
//
// A request inside the fade steps through ST_CLASS, ST_CHECK, ST_DIV (the iterative
// divider, one quotient bit a cycle), ST_ROM (exponential only), ST_MUL and ST_DONE;
// m_tvalid rises once ST_DONE loads the output register. Pass-through requests go
// from ST_CHECK to ST_DONE; a dropped request returns to ST_IDLE, freeing the input.
// aresetn is synchronous, active low; registers return to their reset values.
// A result waits in the output register while the next request is accepted.
module stereo_fadeout_envelope
    import fad_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int GAIN_TABLE_BITS = 10,
    parameter int INDEX_BITS      = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // left_sample, right_sample
    input  wire logic                         s_tuser,  // track_first
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,  // left_out, right_out
    output logic                              m_tuser,  // in_fade
    output logic                              m_tlast,  // fade_last
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int DATA_W   = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int CMP_W    = (INDEX_BITS > START_W) ? INDEX_BITS : START_W;
    localparam int ROM_SIZE = (1 << GAIN_TABLE_BITS) + 1;

    typedef logic [GAIN_W-1:0] gain_rom_t [ROM_SIZE];

    function automatic gain_rom_t build_gain_rom();
        gain_rom_t r;
        for (int i = 0; i < ROM_SIZE; i++) begin
            r[i] = exp_gain(i, GAIN_TABLE_BITS);
        end
        return r;
    endfunction

    localparam gain_rom_t GAIN_ROM = build_gain_rom();

    state_t state_reg;
    state_t state_next;

    logic [MODE_W-1:0]      fade_mode_reg;
    logic [START_W-1:0]     fade_start_reg;
    logic [LEN_W-1:0]       fade_length_reg;
    logic [INDEX_BITS-1:0]  sample_index_reg;

    logic [SAMPLE_BITS-1:0] left_reg;
    logic [SAMPLE_BITS-1:0] right_reg;
    logic [INDEX_BITS-1:0]  idx_reg;
    logic [CMP_W-1:0]       k_reg;
    logic                   before_reg;
    logic                   pass_reg;
    logic                   last_reg;
    logic [GAIN_W-1:0]      rom_data_reg;

    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [SAMPLE_BITS-1:0] left_out_reg;
    logic [SAMPLE_BITS-1:0] right_out_reg;
    logic                   in_fade_reg;
    logic                   fade_last_reg;

    logic                   accept;
    logic [INDEX_BITS-1:0]  idx_now;
    logic [CMP_W:0]         k_full;
    logic                   is_fade;
    logic                   exp_sel;
    logic                   pass_now;
    logic                   drop_now;
    logic [LEN_W-1:0]       n_now;
    logic                   out_free;
    logic                   lane_en;
    logic                   out_load;
    div_cmd_t               div_cmd;
    logic                   div_busy;
    logic                   div_done;
    logic [GAIN_W-1:0]      div_quot;
    logic [GAIN_W-1:0]      gain;
    logic [SAMPLE_BITS-1:0] lane_left;
    logic [SAMPLE_BITS-1:0] lane_right;

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_mode_reg   <= MODE_PASS;
            fade_start_reg  <= '0;
            fade_length_reg <= LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FADE_MODE:   fade_mode_reg   <= cfg_data[MODE_W-1:0];
                REG_FADE_START:  fade_start_reg  <= cfg_data[START_W-1:0];
                REG_FADE_LENGTH: fade_length_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // classification
    assign accept   = s_tvalid && s_tready;
    assign idx_now  = s_tuser ? '0 : sample_index_reg;
    assign k_full   = {1'b0, CMP_W'(idx_reg)} - {1'b0, CMP_W'(fade_start_reg)};
    assign is_fade  = (fade_mode_reg == MODE_LINEAR) || (fade_mode_reg == MODE_EXP);
    assign exp_sel  = fade_mode_reg == MODE_EXP;
    assign pass_now = !is_fade || before_reg;
    assign drop_now = !(k_reg < CMP_W'(fade_length_reg));
    assign n_now    = fade_length_reg - k_reg[LEN_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_index_reg <= '0;
        end else if (accept) begin
            sample_index_reg <= (&idx_now) ? idx_now : idx_now + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            left_reg  <= s_tdata[SAMPLE_BITS-1:0];
            right_reg <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            idx_reg   <= idx_now;
        end
        if (state_reg == ST_CLASS) begin
            k_reg      <= k_full[CMP_W-1:0];
            before_reg <= k_full[CMP_W];
        end
        if (state_reg == ST_CHECK) begin
            pass_reg <= pass_now;
            last_reg <= n_now == LEN_W'(1);
        end
        rom_data_reg <= GAIN_ROM[div_quot[GAIN_TABLE_BITS:0]];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_CLASS;
            ST_CLASS: state_next = ST_CHECK;
            ST_CHECK: begin
                if (pass_now) begin
                    state_next = ST_DONE;
                end else if (drop_now) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:   if (div_done) state_next = exp_sel ? ST_ROM : ST_MUL;
            ST_ROM:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        div_cmd.start = 1'b0;
        div_cmd.shift = exp_sel ? SHIFT_W'(GAIN_TABLE_BITS) : SHIFT_W'(GAIN_FRAC);
        lane_en       = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_CHECK: div_cmd.start = !pass_now && !drop_now;
            ST_MUL:   lane_en = 1'b1;
            ST_DONE:  out_load = out_free;
            default: ;
        endcase
    end

    fad_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .numer   (n_now),
        .denom   (fade_length_reg),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign gain = exp_sel ? rom_data_reg : div_quot;

    fad_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
        .aclk   (aclk),
        .en     (lane_en),
        .sample (left_reg),
        .gain   (gain),
        .result (lane_left)
    );

    fad_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
        .aclk   (aclk),
        .en     (lane_en),
        .sample (right_reg),
        .gain   (gain),
        .result (lane_right)
    );

    // merge and output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            left_out_reg  <= pass_reg ? left_reg  : lane_left;
            right_out_reg <= pass_reg ? right_reg : lane_right;
            in_fade_reg   <= !pass_reg;
            fade_last_reg <= !pass_reg && last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'({right_out_reg, left_out_reg});
    assign m_tuser  = in_fade_reg;
    assign m_tlast  = fade_last_reg;

`ifndef SYNTHESIS
    a_last_in_fade: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("fade_last without in_fade");

    a_index_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_tuser && !(&sample_index_reg)
        |=> sample_index_reg == $past(sample_index_reg) + 1'b1)
        else $error("sample index did not advance");

    a_exp_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done && exp_sel
        |-> div_quot <= GAIN_W'(1 << GAIN_TABLE_BITS))
        else $error("gain ROM address out of range");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("request accepted while divider busy");
`endif

endmodule
`default_nettype wire

### bench/tb_stereo_fadeout_envelope.sv
module tb_stereo_fadeout_envelope;
    import fad_pkg::*;

    localparam int RANDOM_PAIRS  = 1050;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 3000;
    localparam int TABLE_BITS    = 10;
    localparam int TABLE_TOP     = 1 << TABLE_BITS;

    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
    localparam logic [63:0]          Q60_ONE     = 64'd1 << 60;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        in_fade;
        logic        last;
    } faded_pair_t;

    typedef enum bit [1:0] {
        ROW_WRITE,
        ROW_PAIR,
        ROW_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  sel;
        logic [31:0]           wdata;
        logic [15:0]           left;
        logic [15:0]           right;
        logic                  first;
        logic                  kept;
        logic [15:0]           left_o;
        logic [15:0]           right_o;
        logic                  in_fade;
        logic                  last;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_ready;

    stereo_fadeout_envelope dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [16:0]       gain_rom [0:TABLE_TOP];
    logic [MODE_W-1:0] cur_mode   = MODE_PASS;
    logic [31:0]       cur_start  = '0;
    logic [23:0]       cur_length = LEN_RESET;
    logic [31:0]       next_index = '0;

    faded_pair_t pending_faded [$];
    stim_row_t   dir_rows [$];
    int          mismatches   = 0;
    int          pairs_sent   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned ready_hold   = 0;
    bit          calm         = 1'b0;

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = 128'(a) * 128'(b);
        return prod[123:60];
    endfunction

    function automatic logic [63:0] atanh_recip(input logic [63:0] m);
        logic [63:0] sum;
        logic [63:0] p;
        logic [63:0] n;
        sum = '0;
        p   = Q60_ONE / m;
        n   = 64'd1;
        while (p != 0) begin
            sum = sum + p / n;
            p   = p / (m * m);
            n   = n + 64'd2;
        end
        return sum;
    endfunction

    // gain(i) = 1 - exp(-i*ln10/2^TABLE_BITS), series on x/8 then squared three times
    function automatic void build_gain_rom();
        logic [63:0] ln10;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] e;
        ln10 = 64'd3 * (64'd2 * atanh_recip(64'd3)) + 64'd2 * atanh_recip(64'd9);
        for (int i = 0; i <= TABLE_TOP; i++) begin
            x = (ln10 >> TABLE_BITS) * 64'(i)
              + (((ln10 & 64'(TABLE_TOP - 1)) * 64'(i)) >> TABLE_BITS);
            y = x >> 3;
            t = Q60_ONE;
            e = Q60_ONE;
            for (int n = 1; n <= 24; n++) begin
                t = mul_q60(t, y) / 64'(n);
                if (n % 2 == 1) begin
                    e = (e > t) ? e - t : 64'd0;
                end else begin
                    e = e + t;
                end
            end
            repeat (3) e = mul_q60(e, e);
            if (e > Q60_ONE) begin
                e = Q60_ONE;
            end
            gain_rom[i] = 17'((Q60_ONE - e + (64'd1 << 43)) >> 44);
        end
    endfunction

    function automatic logic [15:0] scale_sample(input logic signed [15:0] s,
                                                 input logic [63:0] g);
        longint p;
        p = longint'(s) * longint'(g) + 64'sd32768;
        return 16'(p >>> 16);
    endfunction

    // returns 0 when the pair is dropped
    function automatic bit fade_pair(input logic [15:0] l, input logic [15:0] r,
                                     input logic first, output faded_pair_t res);
        logic [31:0] idx;
        logic [63:0] k;
        logic [63:0] span;
        logic [63:0] g;
        logic [63:0] tbl_i;
        idx        = first ? 32'd0 : next_index;
        next_index = (idx == '1) ? idx : idx + 32'd1;
        res.left    = l;
        res.right   = r;
        res.in_fade = 1'b0;
        res.last    = 1'b0;
        if ((cur_mode != MODE_LINEAR && cur_mode != MODE_EXP) || idx < cur_start) begin
            return 1'b1;
        end
        k    = 64'(idx) - 64'(cur_start);
        span = 64'(cur_length);
        if (k >= span) begin
            return 1'b0;
        end
        if (cur_mode == MODE_LINEAR) begin
            g = ((span - k) << 16) / span;
        end else begin
            tbl_i = ((span - k) << TABLE_BITS) / span;
            if (tbl_i > TABLE_TOP) begin
                tbl_i = TABLE_TOP;
            end
            g = 64'(gain_rom[tbl_i[TABLE_BITS:0]]);
        end
        res.left    = scale_sample(l, g);
        res.right   = scale_sample(r, g);
        res.in_fade = 1'b1;
        res.last    = (k == span - 64'd1);
        return 1'b1;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] sel,
                                          input logic [31:0] wdata);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_WRITE;
        row.sel   = sel;
        row.wdata = wdata;
        return row;
    endfunction

    function automatic stim_row_t pair_row(input logic [15:0] l, input logic [15:0] r,
                                           input logic first);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_PAIR;
        row.left  = l;
        row.right = r;
        row.first = first;
        return row;
    endfunction

    function automatic stim_row_t known_row(input logic [15:0] l, input logic [15:0] r,
                                            input logic first, input logic kept,
                                            input logic [15:0] lo, input logic [15:0] ro,
                                            input logic fade, input logic last);
        stim_row_t row;
        row         = pair_row(l, r, first);
        row.kind    = ROW_KNOWN;
        row.kept    = kept;
        row.left_o  = lo;
        row.right_o = ro;
        row.in_fade = fade;
        row.last    = last;
        return row;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input faded_pair_t got,
                                   input faded_pair_t want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("%0t %s: got %h %h %b %b want %h %h %b %b", $time, what,
                     got.left, got.right, got.in_fade, got.last,
                     want.left, want.right, want.in_fade, want.last);
        end
    endtask

    task automatic send_pair(input stim_row_t row);
        int unsigned gap;
        faded_pair_t res;
        bit          kept;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row.right, row.left};
        s_tuser  <= row.first;
        do @(posedge aclk); while (!s_tready);
        kept = fade_pair(row.left, row.right, row.first, res);
        if (row.kind == ROW_KNOWN) begin
            kept        = row.kept;
            res.left    = row.left_o;
            res.right   = row.right_o;
            res.in_fade = row.in_fade;
            res.last    = row.last;
        end
        if (kept) begin
            pending_faded = {pending_faded, res};
        end
        pairs_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [31:0] wdata);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= wdata;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (sel)
            REG_FADE_MODE:   cur_mode   = wdata[MODE_W-1:0];
            REG_FADE_START:  cur_start  = wdata;
            REG_FADE_LENGTH: cur_length = wdata[LEN_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // dropped requests give no result, so allow them to finish too
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_faded.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    always @(posedge aclk) begin : check_results
        faded_pair_t got;
        faded_pair_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.left    = m_tdata[15:0];
            got.right   = m_tdata[31:16];
            got.in_fade = m_tuser;
            got.last    = m_tlast;
            if (pending_faded.size() == 0) begin
                report_mismatch("unexpected result", got, '0);
            end else begin
                want = pending_faded.pop_front();
                if (got.left !== want.left || got.right !== want.right
                        || got.in_fade !== want.in_fade || got.last !== want.last) begin
                    report_mismatch("result mismatch", got, want);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("FAIL stereo_fadeout_envelope");
                $finish;
            end
        end
    end

    initial begin
        logic [MODE_W-1:0] mode_val;
        logic [31:0]       start_val;
        logic [23:0]       len_val;
        logic [31:0]       wdata;
        int                base;
        int                n;
        bit                broken;

        build_gain_rom();
        dir_rows = '{
            known_row(16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h7FFF, 16'h8000, 1'b0, 1'b0),
            known_row(16'hFFFF, 16'h0001, 1'b0, 1'b1, 16'hFFFF, 16'h0001, 1'b0, 1'b0),
            reg_row(REG_FADE_START, 32'd2),
            reg_row(REG_FADE_LENGTH, 32'd4),
            reg_row(REG_FADE_MODE, 32'(MODE_LINEAR)),
            known_row(16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h7FFF, 16'h8000, 1'b0, 1'b0),
            known_row(16'h1234, 16'hFEDC, 1'b0, 1'b1, 16'h1234, 16'hFEDC, 1'b0, 1'b0),
            known_row(16'h7FFF, 16'h8000, 1'b0, 1'b1, 16'h7FFF, 16'h8000, 1'b1, 1'b0),
            pair_row(16'h7FFF, 16'h8000, 1'b0),
            pair_row(16'h8001, 16'h0000, 1'b0),
            pair_row(16'h5555, 16'hAAAA, 1'b0),
            known_row(16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0),
            known_row(16'h0001, 16'h0001, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0),
            // zero length: everything from the start point on is dropped
            reg_row(REG_FADE_MODE, 32'(MODE_EXP)),
            reg_row(REG_FADE_LENGTH, 32'd0),
            known_row(16'h4321, 16'h8765, 1'b1, 1'b1, 16'h4321, 16'h8765, 1'b0, 1'b0),
            known_row(16'h0F0F, 16'hF0F0, 1'b0, 1'b1, 16'h0F0F, 16'hF0F0, 1'b0, 1'b0),
            known_row(16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0),
            reg_row(REG_FADE_START, 32'd0),
            reg_row(REG_FADE_LENGTH, 32'h00FF_FFFF),
            pair_row(16'h7FFF, 16'h8000, 1'b1),
            pair_row(16'h8000, 16'h7FFF, 1'b0),
            // unused mode code passes through
            reg_row(REG_FADE_MODE, 32'hFFFF_FFFF),
            known_row(16'h8000, 16'h7FFF, 1'b0, 1'b1, 16'h8000, 16'h7FFF, 1'b0, 1'b0),
            reg_row(REG_UNUSED, 32'hA5A5_5A5A),
            reg_row(REG_FADE_START, 32'hFFFF_FFFF),
            reg_row(REG_FADE_MODE, 32'(MODE_LINEAR)),
            known_row(16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h7FFF, 16'h8000, 1'b0, 1'b0),
            reg_row(REG_FADE_START, 32'd0),
            reg_row(REG_FADE_LENGTH, 32'hFF00_0001),
            known_row(16'h8000, 16'h7FFF, 1'b1, 1'b1, 16'h8000, 16'h7FFF, 1'b1, 1'b1),
            known_row(16'h0001, 16'h0001, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0),
            reg_row(REG_FADE_LENGTH, 32'h00FF_FFFF),
            known_row(16'h8000, 16'h7FFF, 1'b1, 1'b1, 16'h8000, 16'h7FFF, 1'b1, 1'b0),
            pair_row(16'h8000, 16'h7FFF, 1'b0)
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                settle();
                write_reg(dir_rows[i].sel, dir_rows[i].wdata);
            end else begin
                send_pair(dir_rows[i]);
            end
        end

        base = pairs_sent;
        while (pairs_sent - base < RANDOM_PAIRS) begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: mode_val = MODE_PASS;
                1: mode_val = MODE_UNUSED;
                2, 3, 4, 5: mode_val = MODE_LINEAR;
                default: mode_val = MODE_EXP;
            endcase
            wdata = $urandom;
            wdata[MODE_W-1:0] = mode_val;
            write_reg(REG_FADE_MODE, wdata);
            case ($urandom_range(0, 9))
                0: start_val = '1;
                1: start_val = $urandom;
                default: start_val = $urandom_range(0, 12);
            endcase
            write_reg(REG_FADE_START, start_val);
            case ($urandom_range(0, 9))
                0: len_val = '0;
                1: len_val = '1;
                2: len_val = 24'($urandom_range(1, 24'hFFFFFF));
                default: len_val = 24'($urandom_range(1, 40));
            endcase
            wdata = $urandom;
            wdata[LEN_W-1:0] = len_val;
            write_reg(REG_FADE_LENGTH, wdata);
            if ($urandom_range(0, 9) == 0) begin
                write_reg(REG_UNUSED, $urandom);
            end

            broken = ($urandom_range(0, 4) == 0);
            if (start_val <= 12 && len_val <= 40) begin
                n = int'(start_val) + int'(len_val) + int'($urandom_range(1, 6));
            end else begin
                n = $urandom_range(8, 40);
            end
            for (int j = 0; j < n; j++) begin
                send_pair(pair_row(pick_sample(), pick_sample(),
                                   broken ? ($urandom_range(0, 7) == 0) : (j == 0)));
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("PASS stereo_fadeout_envelope");
        end else begin
            $display("FAIL stereo_fadeout_envelope");
        end
        $finish;
    end

endmodule

### files.f
sv/fad_pkg.sv
sv/fad_divider.sv
sv/fad_lane.sv
sv/stereo_fadeout_envelope.sv
bench/tb_stereo_fadeout_envelope.sv
